>>> hw/rtl/top_k_min_heap_tracker_top_defines.svh
// assertion macros shared by the tracker checker
`ifndef TOP_K_MIN_HEAP_TRACKER_TOP_DEFINES_SVH
`define TOP_K_MIN_HEAP_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TKH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");

// next-cycle implication, sampled on clk, off while in reset
`define TKH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

>>> hw/rtl/tkh_pkg.sv
// shared types and constants of the top-k tracker
package tkh_pkg;

	localparam int DATA_W = 32;
	localparam int KEEP_W = 5;
	localparam int APB_W  = 32;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_LIST = 1'b1;

	localparam logic REG_KEEP_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LIST = 2'b10
	} state_t;

	typedef struct packed {
		logic                     ins;
		logic                     rot;
		logic signed [DATA_W-1:0] v;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/tkh_cell.sv
// one cell of the descending sorted chain
module tkh_cell (
	input  logic                             clk,
	input  tkh_pkg::cell_ctrl_t              ctrl,
	input  logic                             valid,
	input  logic                             tail,
	input  logic                             prev_ge,
	input  logic signed [tkh_pkg::DATA_W-1:0] prev_val,
	input  logic signed [tkh_pkg::DATA_W-1:0] next_val,
	input  logic signed [tkh_pkg::DATA_W-1:0] head_val,
	output logic signed [tkh_pkg::DATA_W-1:0] val,
	output logic                             ge
);
	import tkh_pkg::*;

	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] ins_val;

	// a valid cell keeps its value while it is at least the new one
	assign ge = valid && (val_q >= ctrl.v);

	always_comb begin
		if (ge) begin
			ins_val = val_q;
		end else if (prev_ge) begin
			ins_val = ctrl.v;
		end else begin
			ins_val = prev_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			val_q <= ins_val;
		end else if (ctrl.rot) begin
			// rotate toward the head, head value wraps to the last valid cell
			val_q <= tail ? head_val : next_val;
		end
	end

	assign val = val_q;

endmodule

>>> hw/rtl/top_k_min_heap_tracker_top.sv
// top level of the top-k tracker: cell chain, sequencer and register port
// insert: result strobe in the next cycle, busy stays low, one insert per cycle while not busy
// check of n kept values: busy while listing, results one per cycle after the sequencer
//   state and result register, set by the chain rotating one position per cycle past cell 0
// check on an empty store: one result in the next cycle, busy stays low
// reset clears the kept count, the sequencer and the strobe; keep_count resets to 16
module top_k_min_heap_tracker_top #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [tkh_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              result_valid,
	output logic                              kind,
	output logic                              accepted,
	output logic signed [tkh_pkg::DATA_W-1:0] listed_value,
	output logic                              empty_res,
	output logic                              last,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [tkh_pkg::APB_W-1:0]         pwdata,
	output logic [tkh_pkg::APB_W-1:0]         prdata,
	output logic                              pready
);
	import tkh_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// register file
	logic [KEEP_W-1:0] keep_count_q;
	logic              reg_wr;
	logic [CW-1:0]     k_eff;

	// chain
	cell_ctrl_t               ctrl;
	logic signed [DATA_W-1:0] val_v [CAPACITY];
	logic [CAPACITY-1:0]      ge_v;
	logic [CAPACITY-1:0]      valid_v;
	logic [CAPACITY-1:0]      tail_v;

	// sequencer
	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          is_ins;
	logic          is_chk;
	logic          room;
	logic          drop_ok;
	logic          ins_ok;
	logic          list_last;

	// result register
	logic                     res_valid_q;
	logic                     kind_q;
	logic                     accepted_q;
	logic signed [DATA_W-1:0] listed_q;
	logic                     empty_q;
	logic                     last_q;

	// register port, word index in paddr[2]
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_KEEP_COUNT);
	assign prdata = (paddr[2] == REG_KEEP_COUNT) ? APB_W'(keep_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_RESET;
		end else if (reg_wr) begin
			keep_count_q <= pwdata[KEEP_W-1:0];
		end
	end

	// zero acts as one, anything above capacity acts as capacity
	always_comb begin
		if (keep_count_q == '0) begin
			k_eff = CW'(1);
		end else if (32'(keep_count_q) > CAPACITY) begin
			k_eff = CW'(CAPACITY);
		end else begin
			k_eff = CW'(keep_count_q);
		end
	end

	// request decode
	assign busy   = (state_q == ST_LIST);
	assign is_ins = start && !busy && (op == OP_INSERT);
	assign is_chk = start && !busy && (op == OP_CHECK);

	// cell 0 is the largest; the store is full once count reaches k, and a full
	// store takes the value only if some kept value is strictly below it
	assign room      = (count_q < k_eff);
	assign drop_ok   = |(valid_v & ~ge_v);
	assign ins_ok    = room || drop_ok;
	assign list_last = (idx_q == count_q - CW'(1));

	assign ctrl.ins = is_ins && ins_ok;
	assign ctrl.rot = busy;
	assign ctrl.v   = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     prev_ge;
		logic signed [DATA_W-1:0] prev_val;
		logic signed [DATA_W-1:0] next_val;

		assign valid_v[i] = (CW'(i) < count_q);
		assign tail_v[i]  = (count_q == CW'(i + 1));

		if (i == 0) begin : g_head
			assign prev_ge  = 1'b1;
			assign prev_val = val_v[0];
		end else begin : g_body
			assign prev_ge  = ge_v[i-1];
			assign prev_val = val_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign next_val = val_v[0];
		end else begin : g_mid
			assign next_val = val_v[i+1];
		end

		tkh_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.valid    (valid_v[i]),
			.tail     (tail_v[i]),
			.prev_ge  (prev_ge),
			.prev_val (prev_val),
			.next_val (next_val),
			.head_val (val_v[0]),
			.val      (val_v[i]),
			.ge       (ge_v[i])
		);
	end

	// sequencer: a check of a non-empty store walks the n kept values while the chain
	// rotates once around, leaving the store as it was
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.ins && room) begin
						count_q <= count_q + CW'(1);
					end
					if (is_chk && (count_q != '0)) begin
						state_q <= ST_LIST;
						idx_q   <= '0;
					end
				end
				ST_LIST: begin
					idx_q <= idx_q + CW'(1);
					if (list_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= is_ins || (is_chk && (count_q == '0)) || busy;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy) begin
			kind_q     <= KIND_LIST;
			accepted_q <= 1'b0;
			listed_q   <= val_v[0];
			empty_q    <= 1'b0;
			last_q     <= list_last;
		end else if (is_ins) begin
			kind_q     <= KIND_ACK;
			accepted_q <= ins_ok;
			listed_q   <= '0;
			empty_q    <= 1'b0;
			last_q     <= 1'b1;
		end else begin
			// empty check
			kind_q     <= KIND_LIST;
			accepted_q <= 1'b0;
			listed_q   <= '0;
			empty_q    <= 1'b1;
			last_q     <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign accepted     = accepted_q;
	assign listed_value = listed_q;
	assign empty_res    = empty_q;
	assign last         = last_q;

endmodule

>>> hw/rtl/tkh_checker.sv
// port-level checker of the top-k tracker and its bind
`include "top_k_min_heap_tracker_top_defines.svh"

module tkh_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              op,
	input logic                              result_valid,
	input logic                              kind,
	input logic signed [tkh_pkg::DATA_W-1:0] listed_value,
	input logic                              empty_res,
	input logic                              last
);
	import tkh_pkg::*;

	// every insert request is answered by a single ack in the next cycle
	`TKH_ASSERT_NEXT(a_ins_ack, start && !busy && (op == OP_INSERT), result_valid && (kind == KIND_ACK) && last && !empty_res)

	// empty check result is a lone final zero listing
	`TKH_ASSERT_NOW(a_empty_form, result_valid && empty_res, last && (kind == KIND_LIST) && (listed_value == '0))

	// listing continues only while the block is busy
	`TKH_ASSERT_NOW(a_list_busy, result_valid && (kind == KIND_LIST) && !last, busy)

	// leaving busy coincides with the final listed value
	`TKH_ASSERT_NOW(a_list_end, $fell(busy), result_valid && last && (kind == KIND_LIST))

endmodule

bind top_k_min_heap_tracker_top tkh_checker u_tkh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.result_valid (result_valid),
	.kind         (kind),
	.listed_value (listed_value),
	.empty_res    (empty_res),
	.last         (last)
);
